[design/cmf_pkg.sv]
// Shared types and constants for the cross-shaped RGB median filter.
// No dependencies; imported by cross_median_filter_rgb.
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int MIN_SIZE          = 2;

    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = 13;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       frame_end;
    } pixel_out_t;

    // Neighborhood and bookkeeping flags carried with an item into the compute stage.
    typedef struct packed {
        logic produce;
        logic has_left;
        logic has_right;
        logic has_up;
        logic has_down;
        logic wr_center;
        logic frame_end;
        logic fwd_right;
    } item_flags_t;

endpackage : cmf_pkg

`default_nettype wire

[design/cross_median_filter_rgb.sv]
// Plus-shaped median filter on an RGBA pixel stream, with two row memories.
// Depends on cmf_pkg for payload types, register indexes and size limits.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one pixel per clock in raster order and returns the filtered
// pixel of the row before, so results start with the second row of a frame and
// the last row comes out while a flush row of image_width items is fed in.
// R, G and B each take the median of the pixel and its in-image up, down,
// left and right neighbors (the middle value at corners, the floor of the mean
// of the two middle values on edges); alpha passes through. Sustained rate is
// one item per clock while the output is not stalled: the center-row memory has
// two read ports (the pixel and its right neighbor) and one write port, the
// row-above memory one of each, and each item reads in the cycle it is
// accepted and writes back when it leaves the compute stage, which a stalled
// output can delay. A result passes from the compute stage into the output
// register when the output is free; while a result waits behind a stalled
// output, the input stalls. The memories need no clearing after reset.
// Registers may be written only while the block is idle; widths outside
// 2..MAX_WIDTH and heights outside 2..4096 are saturated to those limits.
module cross_median_filter_rgb #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire  cmf_pkg::pixel_in_t             in_data,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output cmf_pkg::pixel_out_t                  out_data,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [cmf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [cmf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import cmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = HEIGHT_REG_BITS;

    // Median of up to five values; invalid entries are ignored.
    function automatic logic [7:0] mid_value(input logic [4:0][7:0] v, input logic [4:0] m);
        logic [2:0] n;
        logic [2:0] rank;
        logic [2:0] lo_t;
        logic [2:0] hi_t;
        logic [7:0] lo_v;
        logic [7:0] hi_v;
        logic [8:0] sum;
        n = '0;
        for (int i = 0; i < 5; i++) begin
            n = n + 3'(m[i]);
        end
        lo_t = (n - 3'd1) >> 1;
        hi_t = n >> 1;
        lo_v = '0;
        hi_v = '0;
        for (int i = 0; i < 5; i++) begin
            rank = '0;
            for (int j = 0; j < 5; j++) begin
                if (j != i && m[j] && (v[j] < v[i] || (v[j] == v[i] && j < i))) begin
                    rank = rank + 3'd1;
                end
            end
            if (m[i] && rank == lo_t) begin
                lo_v = v[i];
            end
            if (m[i] && rank == hi_t) begin
                hi_v = v[i];
            end
        end
        sum = {1'b0, lo_v} + {1'b0, hi_v};
        return sum[8:1];
    endfunction

    // Configuration registers.
    logic [WIDTH_REG_BITS-1:0]  width_reg;
    logic [HEIGHT_REG_BITS-1:0] height_reg;

    // Effective frame size after saturation.
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    // Position counters.
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [HW-1:0] row_reg;
    logic [HW-1:0] row_next;
    logic [CW-1:0] c_cur;
    logic [HW-1:0] r_cur;
    logic [WW:0]   c_plus;
    logic [CW-1:0] right_addr;

    // Row memories.
    logic [31:0] center_mem [MAX_WIDTH];
    logic [23:0] above_mem  [MAX_WIDTH];
    logic [31:0] center_rd_reg;
    logic [31:0] right_rd_reg;
    logic [23:0] above_rd_reg;

    // Compute stage.
    logic        s1_valid_reg;
    logic [CW-1:0] s1_addr_reg;
    logic [31:0] s1_pix_reg;
    item_flags_t s1_flags_reg;
    item_flags_t flags_next;
    logic [23:0] s1_fwd_reg;
    logic        s1_adv;
    logic        accept;
    logic        out_free;

    logic [31:0] left_reg;
    logic [23:0] right_rgb;
    logic [4:0]  nb_mask;
    pixel_out_t  result;

    pixel_out_t  out_data_reg;
    logic        out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (32'(width_reg) < MIN_SIZE)
        begin
            w_eff = WW'(MIN_SIZE);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end

        if (32'(height_reg) < MIN_SIZE)
        begin
            h_eff = HW'(MIN_SIZE);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // A count left out of range by a size change restarts at zero.
    always_comb
    begin
        c_cur      = ({1'b0, col_reg} >= (CW+1)'(w_eff)) ? '0 : col_reg;
        r_cur      = (row_reg > h_eff) ? '0 : row_reg;
        c_plus     = (WW+1)'(c_cur) + (WW+1)'(1);
        right_addr = c_cur + CW'(1);

        col_next = c_cur + CW'(1);
        row_next = r_cur;
        if (c_plus >= (WW+1)'(w_eff))
        begin
            col_next = '0;
            row_next = (r_cur >= h_eff) ? '0 : r_cur + HW'(1);
        end

        flags_next.produce   = (r_cur != '0);
        flags_next.has_left  = (c_cur != '0);
        flags_next.has_right = (c_plus < (WW+1)'(w_eff));
        flags_next.has_up    = (r_cur > HW'(1));
        flags_next.has_down  = (r_cur < h_eff);
        flags_next.wr_center = (r_cur < h_eff);
        flags_next.frame_end = (r_cur == h_eff) && (c_plus == (WW+1)'(w_eff));
        // The right neighbor may be written back by the item leaving the compute
        // stage at this very edge (only for a two-pixel row); take it from there.
        flags_next.fwd_right = s1_valid_reg && s1_adv && s1_flags_reg.wr_center &&
                               (s1_addr_reg == right_addr);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_flags_reg.produce || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                left_reg <= center_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            center_rd_reg <= center_mem[c_cur];
            right_rd_reg  <= center_mem[right_addr];
            above_rd_reg  <= above_mem[c_cur];
            s1_addr_reg   <= c_cur;
            s1_pix_reg    <= {in_data.alpha_in, in_data.blue_in,
                              in_data.green_in, in_data.red_in};
            s1_flags_reg  <= flags_next;
            s1_fwd_reg    <= s1_pix_reg[23:0];
        end
        if (s1_adv)
        begin
            above_mem[s1_addr_reg] <= center_rd_reg[23:0];
            if (s1_flags_reg.wr_center)
            begin
                center_mem[s1_addr_reg] <= s1_pix_reg;
            end
        end
    end

    assign right_rgb = s1_flags_reg.fwd_right ? s1_fwd_reg : right_rd_reg[23:0];
    assign nb_mask   = {s1_flags_reg.has_down, s1_flags_reg.has_up,
                        s1_flags_reg.has_right, s1_flags_reg.has_left, 1'b1};

    always_comb
    begin
        result.red_out   = mid_value({s1_pix_reg[7:0], above_rd_reg[7:0], right_rgb[7:0],
                                      left_reg[7:0], center_rd_reg[7:0]}, nb_mask);
        result.green_out = mid_value({s1_pix_reg[15:8], above_rd_reg[15:8], right_rgb[15:8],
                                      left_reg[15:8], center_rd_reg[15:8]}, nb_mask);
        result.blue_out  = mid_value({s1_pix_reg[23:16], above_rd_reg[23:16],
                                      right_rgb[23:16], left_reg[23:16],
                                      center_rd_reg[23:16]}, nb_mask);
        result.alpha_out = center_rd_reg[31:24];
        result.frame_end = s1_flags_reg.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_flags_reg.produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_flags_reg.produce)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : cross_median_filter_rgb

`default_nettype wire

[tb/tb_cross_median_filter_rgb.sv]
// Self-checking testbench for the plus-shaped RGB median filter.
// Needs cmf_pkg and cross_median_filter_rgb; the predictor tracks both row memories itself.
`timescale 1ns / 1ps

module tb_cross_median_filter_rgb;

    import cmf_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 1900;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    typedef enum logic {STEP_CFG, STEP_PIX} step_kind_e;
    typedef enum int {PX_ANY, PX_EXTREME, PX_CLUSTER} px_flavor_e;

    typedef struct packed {
        step_kind_e                kind;
        logic [CFG_IDX_BITS-1:0]   reg_idx;
        logic [CFG_DATA_BITS-1:0]  reg_val;
        pixel_in_t                 px;
        logic                      typed;
        pixel_out_t                want;
    } script_row_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    pixel_in_t                  in_data   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    pixel_out_t                 out_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;

    // Mirror of the block: sizes, both row memories, the left neighbor and the position.
    logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_BITS-1:0] height_reg = HEIGHT_RESET;
    pixel_in_t                  center_row [MAX_WIDTH_DEFAULT];
    pixel_in_t                  above_row  [MAX_WIDTH_DEFAULT];
    pixel_in_t                  left_px    = '0;
    int unsigned                col_pos    = 0;
    int unsigned                row_pos    = 0;

    pixel_out_t                 median_queue [$];
    script_row_t                script_q [$];
    pixel_out_t                 oldest_median;
    int unsigned                mismatch_count = 0;
    int unsigned                cycle_count    = 0;
    int unsigned                send_idle_pct  = 0;
    int unsigned                recv_idle_pct  = 0;
    int unsigned                hold_off_left  = 0;

    cross_median_filter_rgb DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_cross_median_filter_rgb: done, errors");
            $finish;
        end
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [7:0] chan_of(input pixel_in_t p, input int k);
        case (k)
            0:       return p.red_in;
            1:       return p.green_in;
            default: return p.blue_in;
        endcase
    endfunction

    // Sorts the first n values; three give the middle one, four the floored mean of the
    // middle pair, five the median.
    function automatic logic [7:0] cross_median(input logic [4:0][7:0] vals, input int unsigned n);
        logic [7:0] t;
        logic [8:0] pair_sum;
        for (int unsigned i = 1; i < n; i++)
            for (int unsigned j = i; j > 0; j--)
                if (vals[j-1] > vals[j])
                begin
                    t         = vals[j];
                    vals[j]   = vals[j-1];
                    vals[j-1] = t;
                end
        pair_sum = {1'b0, vals[1]} + {1'b0, vals[2]};
        if (n == 3)
            return vals[1];
        if (n == 4)
            return pair_sum[8:1];
        return vals[2];
    endfunction

    function automatic void filter_step(input pixel_in_t px, output bit made,
                                        output pixel_out_t res);
        int unsigned     w;
        int unsigned     h;
        int unsigned     c;
        int unsigned     r;
        int unsigned     n;
        pixel_in_t       ctr;
        logic [4:0][7:0] vals;
        logic [7:0]      m;
        w = clamp_size(32'(width_reg), MAX_WIDTH_DEFAULT);
        h = clamp_size(32'(height_reg), MAX_HEIGHT);
        // A size change can leave the position outside the frame; it then restarts.
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos > h)
            row_pos = 0;
        c    = col_pos;
        r    = row_pos;
        ctr  = center_row[c];
        made = 1'b0;
        res  = '0;
        if (r > 0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vals    = '0;
                vals[0] = chan_of(ctr, k);
                n       = 1;
                if (c > 0)
                begin
                    vals[n] = chan_of(left_px, k);
                    n++;
                end
                if (c + 1 < w)
                begin
                    vals[n] = chan_of(center_row[c+1], k);
                    n++;
                end
                if (r > 1)
                begin
                    vals[n] = chan_of(above_row[c], k);
                    n++;
                end
                if (r < h)
                begin
                    vals[n] = chan_of(px, k);
                    n++;
                end
                m = cross_median(vals, n);
                case (k)
                    0:       res.red_out   = m;
                    1:       res.green_out = m;
                    default: res.blue_out  = m;
                endcase
            end
            res.alpha_out = ctr.alpha_in;
            res.frame_end = (r == h) && (c + 1 == w);
            made = 1'b1;
        end
        above_row[c] = ctr;
        left_px      = ctr;
        if (r < h)
            center_row[c] = px;
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos > h)
                row_pos = 0;
        end
    endfunction

    function automatic pixel_in_t mk_px(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a);
        pixel_in_t p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        p.alpha_in = a;
        return p;
    endfunction

    function automatic pixel_out_t mk_res(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a,
                                          input logic fe);
        pixel_out_t p;
        p.red_out   = r;
        p.green_out = g;
        p.blue_out  = b;
        p.alpha_out = a;
        p.frame_end = fe;
        return p;
    endfunction

    function automatic script_row_t pix_typed(input pixel_in_t px, input pixel_out_t want);
        script_row_t row;
        row       = '0;
        row.kind  = STEP_PIX;
        row.px    = px;
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic script_row_t pix_step(input pixel_in_t px);
        script_row_t row;
        row       = pix_typed(px, '0);
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic script_row_t cfg_step(input logic [CFG_IDX_BITS-1:0] idx,
                                             input logic [CFG_DATA_BITS-1:0] val);
        script_row_t row;
        row         = '0;
        row.kind    = STEP_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic void add_row(input script_row_t row);
        script_q.insert(script_q.size(), row);
    endfunction

    function automatic pixel_in_t rand_pixel(input px_flavor_e flavor, input logic [7:0] base);
        logic [2:0][7:0] ch;
        logic [7:0]      a;
        for (int k = 0; k < 3; k++)
            case (flavor)
                PX_ANY:     ch[k] = 8'($urandom);
                PX_EXTREME: ch[k] = $urandom_range(1) ? 8'hFF : 8'h00;
                default:    ch[k] = base + 8'($urandom_range(3));
            endcase
        a = 8'($urandom);
        return mk_px(ch[0], ch[1], ch[2], a);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker: every accepted item is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (median_queue.size() == 0)
            begin
                $error("result with no prediction waiting: %h", out_data);
                mismatch_count++;
            end
            else
            begin
                oldest_median = median_queue.pop_front();
                check_field("red_out", oldest_median.red_out, out_data.red_out);
                check_field("green_out", oldest_median.green_out, out_data.green_out);
                check_field("blue_out", oldest_median.blue_out, out_data.blue_out);
                check_field("alpha_out", oldest_median.alpha_out, out_data.alpha_out);
                check_field("frame_end", 8'(oldest_median.frame_end), 8'(out_data.frame_end));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_stall <= 1'b1;
                hold_off_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item was taken.
    task automatic send_pixel(input pixel_in_t px, input bit typed, input pixel_out_t typed_res);
        bit         made;
        pixel_out_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
        filter_step(px, made, res);
        if (made)
            median_queue.insert(median_queue.size(), typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (median_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val[WIDTH_REG_BITS-1:0];
        else
            height_reg = val[HEIGHT_REG_BITS-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned               frame_no;
        int unsigned               small_items;
        int unsigned               n_items;
        logic [CFG_DATA_BITS-1:0]  w_set;
        logic [CFG_DATA_BITS-1:0]  h_set;
        px_flavor_e                flavor;
        logic [7:0]                base;

        // Flat white 2x2 frame: every median is white and alpha follows the center pixel.
        add_row(cfg_step(REG_IMAGE_WIDTH, 13'd2));
        add_row(cfg_step(REG_IMAGE_HEIGHT, 13'd2));
        add_row(pix_step(mk_px(8'hFF, 8'hFF, 8'hFF, 8'h00)));
        add_row(pix_step(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hFF)));
        add_row(pix_typed(mk_px(8'hFF, 8'hFF, 8'hFF, 8'h5A),
                          mk_res(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0)));
        add_row(pix_typed(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hA5),
                          mk_res(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0)));
        // Flush row values must not reach any median.
        add_row(pix_typed(mk_px(8'h3C, 8'hC3, 8'h00, 8'h66),
                          mk_res(8'hFF, 8'hFF, 8'hFF, 8'h5A, 1'b0)));
        add_row(pix_typed(mk_px(8'h00, 8'h00, 8'h00, 8'h00),
                          mk_res(8'hFF, 8'hFF, 8'hFF, 8'hA5, 1'b1)));
        // Sizes below the minimum saturate; bits above the width field are dropped.
        add_row(cfg_step(REG_IMAGE_WIDTH, 13'h1801));
        add_row(cfg_step(REG_IMAGE_HEIGHT, 13'd0));
        add_row(pix_step(mk_px(8'h00, 8'hFF, 8'h00, 8'hFF)));
        add_row(pix_step(mk_px(8'hFF, 8'h00, 8'hFF, 8'h00)));
        add_row(pix_step(mk_px(8'h00, 8'h00, 8'h00, 8'h00)));
        add_row(pix_step(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hFF)));
        add_row(pix_step(mk_px(8'h00, 8'h00, 8'h00, 8'h00)));
        add_row(pix_step(mk_px(8'hFF, 8'hFF, 8'hFF, 8'hFF)));
        // Three rows of a taller frame, then the height drops below the current row,
        // which must restart the frame at row zero.
        add_row(cfg_step(REG_IMAGE_HEIGHT, 13'd4));
        add_row(pix_step(mk_px(8'h10, 8'hF0, 8'h80, 8'h01)));
        add_row(pix_step(mk_px(8'h20, 8'hE0, 8'h81, 8'h02)));
        add_row(pix_step(mk_px(8'h30, 8'hD0, 8'h7F, 8'h03)));
        add_row(pix_step(mk_px(8'h40, 8'hC0, 8'h82, 8'h04)));
        add_row(pix_step(mk_px(8'h50, 8'hB0, 8'h7E, 8'h05)));
        add_row(pix_step(mk_px(8'h60, 8'hA0, 8'h83, 8'h06)));
        add_row(cfg_step(REG_IMAGE_HEIGHT, 13'd1));
        add_row(pix_step(mk_px(8'h01, 8'h02, 8'h03, 8'h11)));
        add_row(pix_step(mk_px(8'hFE, 8'hFD, 8'hFC, 8'h22)));
        add_row(pix_step(mk_px(8'h7F, 8'h80, 8'h81, 8'h33)));
        add_row(pix_step(mk_px(8'h80, 8'h7F, 8'h7E, 8'h44)));
        add_row(pix_step(mk_px(8'h55, 8'hAA, 8'h55, 8'h55)));
        add_row(pix_step(mk_px(8'hAA, 8'h55, 8'hAA, 8'hAA)));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 31;
        recv_idle_pct = 50;
        foreach (script_q[i])
        begin
            if (script_q[i].kind == STEP_CFG)
                write_reg(script_q[i].reg_idx, script_q[i].reg_val);
            else
                send_pixel(script_q[i].px, script_q[i].typed, script_q[i].want);
        end

        // Random small frames; some sizes saturate or carry bits above the width field.
        frame_no    = 0;
        small_items = 0;
        while (small_items < RANDOM_ITEMS)
        begin
            if (small_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 50;
            end
            else if (small_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if ($urandom_range(7) == 0)
                w_set = 13'($urandom_range(1));
            else if ($urandom_range(7) == 0)
                w_set = 13'($urandom_range(13, 64));
            else
                w_set = 13'($urandom_range(2, 12));
            if ($urandom_range(5) == 0)
                w_set = 13'(w_set + 13'h0800 * $urandom_range(1, 3));
            if ($urandom_range(7) == 0)
                h_set = 13'($urandom_range(1));
            else if (w_set[WIDTH_REG_BITS-1:0] > 12)
                h_set = 13'($urandom_range(2, 3));
            else
                h_set = 13'($urandom_range(2, 8));
            write_reg(REG_IMAGE_WIDTH, w_set);
            write_reg(REG_IMAGE_HEIGHT, h_set);
            n_items = clamp_size(32'(width_reg), MAX_WIDTH_DEFAULT)
                      * (clamp_size(32'(height_reg), MAX_HEIGHT) + 1);

            case ($urandom_range(3))
                0:       flavor = PX_EXTREME;
                1:       flavor = PX_CLUSTER;
                default: flavor = PX_ANY;
            endcase
            base = 8'($urandom);

            for (int unsigned i = 0; i < n_items; i++)
            begin
                // Mid-frame: once the receiver holds off so the block backs up into its
                // input, and once the sender waits for every result to come out.
                if (frame_no == 2 && i == n_items / 2)
                    hold_off_left = HOLD_OFF_CYCLES;
                if (frame_no == 3 && i == n_items / 2)
                    wait_results_drained();
                send_pixel(rand_pixel(flavor, base), 1'b0, '0);
            end
            small_items += n_items;
            frame_no++;
        end

        wait_results_drained();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_cross_median_filter_rgb: done, clean");
        else
            $display("tb_cross_median_filter_rgb: done, errors");
        $finish;
    end

endmodule

[sim.f]
design/cmf_pkg.sv
design/cross_median_filter_rgb.sv
tb/tb_cross_median_filter_rgb.sv
